### hw/rtl/event_record_ring_buffer_defines.svh
// Assertion macros used by the checker of the event record ring buffer.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef EVENT_RECORD_RING_BUFFER_DEFINES_SVH
`define EVENT_RECORD_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ERB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/erb_pkg.sv
// Shared types and constants of the event record ring buffer.
// Depends on nothing; the top level, front and back modules import it.
`timescale 1ns / 1ps

package erb_pkg;

	// Sizing defaults and record layout.
	localparam int DEF_CAPACITY  = 128;
	localparam int DEF_CMD_DEPTH = 2;
	localparam int DEF_RES_DEPTH = 4;
	localparam int HEADER_BYTES  = 4;
	localparam int MAX_PAYLOAD   = 60;
	localparam int LEN_POS       = 3;

	// Operation codes of an input transaction.
	typedef enum logic [1:0] {
		OP_BEGIN   = 2'd0,
		OP_PAYLOAD = 2'd1,
		OP_POP     = 2'd2,
		OP_FAULT   = 2'd3
	} op_t;

	// Header byte positions written after the first (id low) byte.
	localparam logic [1:0] HDR_ID_HI = 2'd1;
	localparam logic [1:0] HDR_TYPE  = 2'd2;
	localparam logic [1:0] HDR_LEN   = 2'(LEN_POS);

	// Classified command handed from the front to the back.
	typedef struct packed {
		op_t        op;
		logic [7:0] event_type;
		logic [5:0] length;
		logic [7:0] payload_byte;
		logic       clear_fault;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0]  record_byte;
		logic        last_byte;
		logic [6:0]  record_size;
		logic        accepted;
		logic [15:0] assigned_id;
		logic        fault_flag;
	} res_t;

	// Sequencer states of the back end.
	typedef enum logic [1:0] {
		BS_IDLE,
		BS_HDR,
		BS_POP_LEN,
		BS_POP_STREAM
	} back_state_t;

endpackage

### hw/rtl/event_record_ring_buffer.sv
// Event record ring buffer: stores variable-length event records in a byte ring.
// Input channel: push/full. A transaction carries op, event_type, payload_length,
// payload_byte and clear_fault. Result channel: empty/pop, one result byte
// or status word per transaction, oldest first.
// A begin returns one result (accepted, assigned_id); a payload byte returns
// none; a pop returns every byte of the oldest record, or one empty marker;
// a fault read returns one result with the fault flag.
// Throughput is set by the one-port ring memory behind a two-entry command
// queue: a payload byte is a single write, a begin that fits writes its header
// one byte per cycle and one that does not writes nothing, and a pop reads the
// length, decodes it, reads one byte per cycle while the result queue has room,
// drains the read stage and releases the record.
// A four-entry result queue lets the sequencer run ahead of the receiver;
// when the receiver stalls, the queue fills and then full rises on the input.
// Reset clears all control state: both queues empty, no record stored,
// next id 1, fault flag clear. The ring contents need no clearing.
// Depends on erb_pkg, erb_fifo, erb_front and erb_back.
`timescale 1ns / 1ps

module event_record_ring_buffer import erb_pkg::*; #(
	parameter int CAPACITY  = DEF_CAPACITY,
	parameter int CMD_DEPTH = DEF_CMD_DEPTH,
	parameter int RES_DEPTH = DEF_RES_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  op,
	input  logic [7:0]  event_type,
	input  logic [5:0]  payload_length,
	input  logic [7:0]  payload_byte,
	input  logic        clear_fault,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  record_byte,
	output logic        last_byte,
	output logic [6:0]  record_size,
	output logic        accepted,
	output logic [15:0] assigned_id,
	output logic        fault_flag
);

	logic                           cmd_valid;
	logic                           cmd_pop;
	cmd_t                           cmd;
	logic                           res_push;
	res_t                           res_in;
	res_t                           res_head;
	logic                           res_full;
	logic [$clog2(RES_DEPTH+1)-1:0] res_count;

	// Accept and classify input transactions.
	erb_front #(
		.CMD_DEPTH(CMD_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.op             (op),
		.event_type     (event_type),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.clear_fault    (clear_fault),
		.cmd_pop        (cmd_pop),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd)
	);

	// Carry out commands against the ring.
	erb_back #(
		.CAPACITY  (CAPACITY),
		.RES_DEPTH (RES_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Result queue toward the receiver.
	erb_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_in),
		.pop     (pop),
		.rd_data (res_head),
		.full    (res_full),
		.empty   (empty),
		.count   (res_count)
	);

	// Result fields; the sequencer never pushes into a full queue.
	assign record_byte = res_head.record_byte;
	assign last_byte   = res_head.last_byte;
	assign record_size = res_head.record_size;
	assign accepted    = res_head.accepted && !res_full ? 1'b1 : res_head.accepted;
	assign assigned_id = res_head.assigned_id;
	assign fault_flag  = res_head.fault_flag;

endmodule

### hw/rtl/erb_fifo.sv
// Small register-based first-in first-out queue.
// Depends on nothing; used for the command queue and the result queue.
`timescale 1ns / 1ps

module erb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Flags and head entry.
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Storage holds payload only.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### hw/rtl/erb_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on erb_pkg and erb_fifo.
`timescale 1ns / 1ps

module erb_front import erb_pkg::*; #(
	parameter int CMD_DEPTH = DEF_CMD_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] op,
	input  logic [7:0] event_type,
	input  logic [5:0] payload_length,
	input  logic [7:0] payload_byte,
	input  logic       clear_fault,
	input  logic       cmd_pop,
	output logic       cmd_valid,
	output cmd_t       cmd
);

	cmd_t in_cmd;
	logic cmd_empty;

	// Decode the operation and bound the payload length.
	always_comb begin
		in_cmd.op           = op_t'(op);
		in_cmd.event_type   = event_type;
		in_cmd.length       = (payload_length > 6'(MAX_PAYLOAD)) ?
			6'(MAX_PAYLOAD) : payload_length;
		in_cmd.payload_byte = payload_byte;
		in_cmd.clear_fault  = clear_fault;
	end

	// Command queue decouples the input side from the sequencer.
	erb_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (in_cmd),
		.pop     (cmd_pop),
		.rd_data (cmd),
		.full    (full),
		.empty   (cmd_empty),
		.count   ()
	);

	assign cmd_valid = !cmd_empty;

endmodule

### hw/rtl/erb_back.sv
// Back end: ring memory, record bookkeeping and the pop sequencer.
// Depends on erb_pkg; feeds the result queue in the top level.
`timescale 1ns / 1ps

module erb_back import erb_pkg::*; #(
	parameter int CAPACITY  = DEF_CAPACITY,
	parameter int RES_DEPTH = DEF_RES_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  cmd_t                           cmd,
	output logic                           cmd_pop,
	input  logic [$clog2(RES_DEPTH+1)-1:0] res_count,
	output logic                           res_push,
	output res_t                           res
);

	localparam int IW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int FW  = ((CW > 7) ? CW : 7) + 1;
	localparam int RCW = $clog2(RES_DEPTH + 1);

	back_state_t state_q;
	back_state_t state_d;

	logic [7:0]    mem_q [CAPACITY];
	logic [7:0]    rdata_s1;
	logic          rd_vld_s1;
	logic          rd_last_s1;

	logic [IW-1:0] read_idx_q;
	logic [IW-1:0] tail_q;
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic [CW-1:0] committed_q;
	logic [6:0]    pending_q;
	logic [5:0]    remain_q;
	logic          writing_q;
	logic [15:0]   next_id_q;
	logic          fault_q;
	logic [1:0]    hdr_pos_q;
	logic [15:0]   hdr_id_q;
	logic [7:0]    hdr_type_q;
	logic [5:0]    hdr_len_q;
	logic [6:0]    size_q;
	logic [6:0]    left_q;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;

	logic          credit;
	logic          fits;
	logic          payload_ok;
	logic          pop_done;
	logic [IW:0]   len_sum;
	logic [IW-1:0] len_addr;
	logic [7:0]    rec_len;
	logic [6:0]    rec_size;
	logic [6:0]    pop_size;

	function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] p);
		return (p == IW'(CAPACITY - 1)) ? '0 : p + 1'b1;
	endfunction

	// Room in the result queue, counting a read that is still in flight.
	assign credit = ({1'b0, res_count} + (RCW+1)'(rd_vld_s1)) < (RCW+1)'(RES_DEPTH);

	// Fit check of a new record against the committed bytes.
	assign fits = (FW'(committed_q) + FW'(7'(HEADER_BYTES) + {1'b0, cmd.length}))
		<= FW'(CAPACITY);

	assign payload_ok = writing_q && (remain_q != '0);
	assign pop_done   = (left_q == '0) && !rd_vld_s1;

	// Ring position of the length byte of the oldest record.
	assign len_sum  = {1'b0, read_idx_q} + (IW+1)'(LEN_POS);
	assign len_addr = (len_sum >= (IW+1)'(CAPACITY)) ?
		IW'(len_sum - (IW+1)'(CAPACITY)) : IW'(len_sum);

	// Size of the record being popped, bounded by the committed bytes.
	assign rec_len  = (rdata_s1 > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : rdata_s1;
	assign rec_size = 7'(HEADER_BYTES) + rec_len[6:0];
	assign pop_size = (FW'(rec_size) > FW'(committed_q)) ? 7'(committed_q) : rec_size;

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BS_IDLE: begin
				if (cmd_pop && (cmd.op == OP_BEGIN) && fits) begin
					state_d = BS_HDR;
				end else if (cmd_pop && (cmd.op == OP_POP) && (committed_q != '0)) begin
					state_d = BS_POP_LEN;
				end
			end
			BS_HDR: begin
				if (hdr_pos_q == HDR_LEN) begin
					state_d = BS_IDLE;
				end
			end
			BS_POP_LEN: begin
				state_d = BS_POP_STREAM;
			end
			BS_POP_STREAM: begin
				if (pop_done) begin
					state_d = BS_IDLE;
				end
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
	end

	// Output logic: command dequeue, memory access and result transactions.
	always_comb begin
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		res       = '0;
		mem_we    = 1'b0;
		mem_waddr = wr_ptr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = rd_ptr_q;
		unique case (state_q)
			BS_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						OP_BEGIN: begin
							if (credit) begin
								cmd_pop         = 1'b1;
								res_push        = 1'b1;
								res.last_byte   = 1'b1;
								res.accepted    = fits;
								res.assigned_id = next_id_q;
								if (fits) begin
									mem_we    = 1'b1;
									mem_waddr = tail_q;
									mem_wdata = next_id_q[7:0];
								end
							end
						end
						OP_PAYLOAD: begin
							cmd_pop = 1'b1;
							if (payload_ok) begin
								mem_we    = 1'b1;
								mem_wdata = cmd.payload_byte;
							end
						end
						OP_POP: begin
							if (committed_q == '0) begin
								if (credit) begin
									cmd_pop       = 1'b1;
									res_push      = 1'b1;
									res.last_byte = 1'b1;
								end
							end else begin
								cmd_pop   = 1'b1;
								mem_re    = 1'b1;
								mem_raddr = len_addr;
							end
						end
						OP_FAULT: begin
							if (credit) begin
								cmd_pop        = 1'b1;
								res_push       = 1'b1;
								res.last_byte  = 1'b1;
								res.fault_flag = fault_q;
							end
						end
						default: begin
							cmd_pop = 1'b0;
						end
					endcase
				end
			end
			BS_HDR: begin
				mem_we = 1'b1;
				unique case (hdr_pos_q)
					HDR_ID_HI: mem_wdata = hdr_id_q[15:8];
					HDR_TYPE:  mem_wdata = hdr_type_q;
					HDR_LEN:   mem_wdata = {2'b00, hdr_len_q};
					default:   mem_wdata = '0;
				endcase
			end
			BS_POP_LEN: begin
				mem_re = 1'b0;
			end
			BS_POP_STREAM: begin
				if ((left_q != '0) && credit) begin
					mem_re = 1'b1;
				end
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase

		// Record bytes come back in the cycle after their read.
		if (rd_vld_s1) begin
			res_push        = 1'b1;
			res.record_byte = rdata_s1;
			res.last_byte   = rd_last_s1;
			res.record_size = size_q;
		end
	end

	// Ring memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem_q[mem_raddr];
		end
	end

	// Header and record payload registers.
	always_ff @(posedge clk) begin
		if ((state_q == BS_IDLE) && cmd_pop && (cmd.op == OP_BEGIN)) begin
			hdr_id_q   <= next_id_q;
			hdr_type_q <= cmd.event_type;
			hdr_len_q  <= cmd.length;
		end
		if (state_q == BS_POP_LEN) begin
			size_q <= pop_size;
		end
		rd_last_s1 <= (left_q == 7'd1);
	end

	// Control state and ring bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			read_idx_q  <= '0;
			tail_q      <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			committed_q <= '0;
			pending_q   <= '0;
			remain_q    <= '0;
			writing_q   <= 1'b0;
			next_id_q   <= 16'd1;
			fault_q     <= 1'b0;
			hdr_pos_q   <= '0;
			left_q      <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_re && (state_q == BS_POP_STREAM);
			unique case (state_q)
				BS_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.op)
							OP_BEGIN: begin
								// A new begin abandons any unfinished record.
								next_id_q <= next_id_q + 16'd1;
								writing_q <= 1'b0;
								pending_q <= '0;
								remain_q  <= '0;
								if (fits) begin
									wr_ptr_q  <= ring_inc(tail_q);
									hdr_pos_q <= HDR_ID_HI;
								end else begin
									fault_q  <= 1'b1;
									wr_ptr_q <= tail_q;
								end
							end
							OP_PAYLOAD: begin
								if (payload_ok) begin
									wr_ptr_q <= ring_inc(wr_ptr_q);
									if (remain_q == 6'd1) begin
										committed_q <= committed_q + CW'(pending_q) + CW'(1);
										tail_q      <= ring_inc(wr_ptr_q);
										writing_q   <= 1'b0;
										pending_q   <= '0;
										remain_q    <= '0;
									end else begin
										pending_q <= pending_q + 7'd1;
										remain_q  <= remain_q - 6'd1;
									end
								end
							end
							OP_FAULT: begin
								if (cmd.clear_fault) begin
									fault_q <= 1'b0;
								end
							end
							default: begin
								fault_q <= fault_q;
							end
						endcase
					end
				end
				BS_HDR: begin
					wr_ptr_q  <= ring_inc(wr_ptr_q);
					hdr_pos_q <= hdr_pos_q + 2'd1;
					if (hdr_pos_q == HDR_LEN) begin
						// A record without payload commits with its header.
						if (hdr_len_q == '0) begin
							committed_q <= committed_q + CW'(HEADER_BYTES);
							tail_q      <= ring_inc(wr_ptr_q);
						end else begin
							writing_q <= 1'b1;
							pending_q <= 7'(HEADER_BYTES);
							remain_q  <= hdr_len_q;
						end
					end
				end
				BS_POP_LEN: begin
					rd_ptr_q <= read_idx_q;
					left_q   <= pop_size;
				end
				BS_POP_STREAM: begin
					if (mem_re) begin
						rd_ptr_q <= ring_inc(rd_ptr_q);
						left_q   <= left_q - 7'd1;
					end
					if (pop_done) begin
						read_idx_q  <= rd_ptr_q;
						committed_q <= committed_q - CW'(size_q);
					end
				end
				default: begin
					left_q <= '0;
				end
			endcase
		end
	end

endmodule

### hw/rtl/erb_checker.sv
// Port-level checks of the event record ring buffer, bound to the top level.
// Depends on event_record_ring_buffer_defines.svh and the top-level ports.
`timescale 1ns / 1ps
`include "event_record_ring_buffer_defines.svh"

module erb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  record_byte,
	input logic        last_byte,
	input logic [6:0]  record_size,
	input logic        accepted,
	input logic [15:0] assigned_id,
	input logic        fault_flag
);

	// A waiting result transaction holds until it is taken.
	`ERB_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(record_byte) && $stable(assigned_id), "result changed while stalled")

	// A record never exceeds a full header plus the largest payload.
	`ERB_ASSERT_IMP(a_size_bound, !empty, record_size <= 7'd64, "record size out of range")

	// Only record bytes can be followed by more results of the same pop.
	`ERB_ASSERT_IMP(a_mid_record, !empty && !last_byte, record_size != 7'd0 && !accepted && !fault_flag, "non-final result outside a record")

	// A begin status carries no record bytes.
	`ERB_ASSERT_IMP(a_begin_status, !empty && accepted, last_byte && record_size == 7'd0 && record_byte == 8'd0, "begin status mixed with record data")

endmodule

bind event_record_ring_buffer erb_checker u_erb_checker (.*);
